/* sv/cpr_pkg.sv */
// Package for the convex polygon round buffer: widths, constants, job type
// and the CORDIC arctangent table. Used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package cpr_pkg;
  localparam int MAX_POINTS   = 64;
  localparam int CORDIC_STEPS = 16;
  localparam int ITW          = $clog2(CORDIC_STEPS);
  localparam int PW           = $clog2(MAX_POINTS + 1);
  localparam int NW           = PW + 19;

  localparam logic [15:0] QUARTER_TURN = 16'h4000;
  localparam logic [29:0] GAIN_Q30     = 30'd652032875;

  // Configuration register indexes.
  localparam logic REG_RADIUS = 1'b0;
  localparam logic REG_CV     = 1'b1;

  typedef struct packed {
    logic [15:0]        start;
    logic [17:0]        s2;
    logic [PW-1:0]      d;
    logic [PW-1:0]      p;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
  } cpr_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cpr_qstat_t;

  // atan(2^-i) in units of 2^-32 turn.
  function automatic logic [31:0] atab(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0: v = 32'd536870912;  5'd1: v = 32'd316933406;
      5'd2: v = 32'd167458907;  5'd3: v = 32'd85004756;
      5'd4: v = 32'd42667331;   5'd5: v = 32'd21354465;
      5'd6: v = 32'd10679838;   5'd7: v = 32'd5340245;
      5'd8: v = 32'd2670163;    5'd9: v = 32'd1335087;
      5'd10: v = 32'd667544;    5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;    5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;     5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;     5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;       5'd21: v = 32'd326;
      5'd22: v = 32'd163;       5'd23: v = 32'd81;
      5'd24: v = 32'd41;        5'd25: v = 32'd20;
      5'd26: v = 32'd10;        5'd27: v = 32'd5;
      5'd28: v = 32'd3;         5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

/* sv/cpr_front.sv */
// Front end: accepts a vertex word, finds the arc start and end angles with a
// shared CORDIC vectoring unit and queues one arc job. Depends on cpr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cpr_front import cpr_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [191:0] in_tdata,
  input  wire logic         in_tuser,
  input  wire logic [6:0]   cv,
  output logic              q_push,
  output cpr_job_t          q_job,
  input  wire cpr_qstat_t   q_stat
);
  localparam logic [2:0] F_IDLE = 3'd0, F_LOAD = 3'd1, F_NORM = 3'd2,
                         F_ITER = 3'd3, F_FIN = 3'd4, F_SPAN = 3'd5, F_PUSH = 3'd6;
  localparam logic signed [42:0] NLIM = 43'sd1 <<< 39;
  localparam logic signed [42:0] SLIM = 43'sd1 <<< 31;

  logic [2:0]         state_r;
  logic               phase_r;
  logic signed [31:0] px_r, py_r, cx_r, cy_r, nx_r, ny_r;
  logic signed [42:0] x_r, y_r;
  logic [31:0]        z_r, base_r;
  logic [ITW-1:0]     it_r;
  logic [15:0]        start_r, end_r;
  cpr_job_t           job_r;

  logic signed [32:0] vx, vy;
  logic signed [42:0] ay, xs, ys;
  logic [31:0]        asum;
  logic [15:0]        span;
  logic [22:0]        sprod;
  logic [23:0]        sround;
  logic [PW-1:0]      steps, n_clamped;

  always_comb begin
    if (phase_r) begin
      vx = 33'(nx_r) - 33'(cx_r);
      vy = 33'(ny_r) - 33'(cy_r);
    end else begin
      vx = 33'(px_r) - 33'(cx_r);
      vy = 33'(py_r) - 33'(cy_r);
    end
    ay     = (y_r < 0) ? -y_r : y_r;
    xs     = x_r >>> it_r;
    ys     = y_r >>> it_r;
    asum   = base_r + z_r + 32'h8000;
    span   = end_r - start_r;
    sprod  = 23'(span) * 23'(cv);
    sround = 24'(sprod) + 24'd32768;
    if (sround[23:16] > 8'(MAX_POINTS - 1)) steps = PW'(MAX_POINTS - 1);
    else steps = PW'(sround[23:16]);
    if (cv == 7'd0) n_clamped = PW'(1);
    else if (8'(cv) > 8'(MAX_POINTS)) n_clamped = PW'(MAX_POINTS);
    else n_clamped = PW'(cv);
  end

  assign in_tready = (state_r == F_IDLE);
  assign q_push    = (state_r == F_PUSH) && !q_stat.full;
  assign q_job     = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      phase_r <= 1'b0;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_tvalid) begin
            px_r <= in_tdata[31:0];
            py_r <= in_tdata[63:32];
            cx_r <= in_tdata[95:64];
            cy_r <= in_tdata[127:96];
            nx_r <= in_tdata[159:128];
            ny_r <= in_tdata[191:160];
            phase_r <= 1'b0;
            if (in_tuser) begin
              job_r.start <= 16'd0;
              job_r.s2    <= 18'd131072;
              job_r.d     <= n_clamped;
              job_r.p     <= n_clamped;
              job_r.cx    <= in_tdata[95:64];
              job_r.cy    <= in_tdata[127:96];
              state_r     <= F_PUSH;
            end else begin
              state_r <= F_LOAD;
            end
          end
        end
        F_LOAD: begin
          z_r <= 32'd0;
          if (vx == 0 && vy == 0) begin
            // A zero vector points at angle zero.
            base_r  <= 32'd0;
            state_r <= F_FIN;
          end else if (vx < 0) begin
            x_r     <= -43'(vx);
            y_r     <= -43'(vy);
            base_r  <= 32'h8000_0000;
            state_r <= F_NORM;
          end else begin
            x_r     <= 43'(vx);
            y_r     <= 43'(vy);
            base_r  <= 32'd0;
            state_r <= F_NORM;
          end
        end
        F_NORM: begin
          if (x_r < NLIM && ay < NLIM) begin
            if (x_r < SLIM && ay < SLIM) begin
              x_r <= x_r <<< 8;
              y_r <= y_r <<< 8;
            end else begin
              x_r <= x_r <<< 1;
              y_r <= y_r <<< 1;
            end
          end else begin
            it_r    <= '0;
            state_r <= F_ITER;
          end
        end
        F_ITER: begin
          if (y_r > 0) begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + atab(5'(it_r));
          end else begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - atab(5'(it_r));
          end
          if (it_r == ITW'(CORDIC_STEPS - 1)) state_r <= F_FIN;
          else it_r <= it_r + 1'b1;
        end
        F_FIN: begin
          if (!phase_r) begin
            start_r <= asum[31:16] + QUARTER_TURN;
            phase_r <= 1'b1;
            state_r <= F_LOAD;
          end else begin
            end_r   <= asum[31:16] - QUARTER_TURN;
            state_r <= F_SPAN;
          end
        end
        F_SPAN: begin
          job_r.start <= start_r;
          job_r.s2    <= {1'b0, span, 1'b0};
          job_r.d     <= (steps == '0) ? PW'(1) : steps;
          job_r.p     <= (steps == '0) ? PW'(2) : steps + 1'b1;
          job_r.cx    <= cx_r;
          job_r.cy    <= cy_r;
          state_r     <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_stat.full) state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* sv/cpr_fifo.sv */
// Two-entry job queue between the front end and the point generator.
// Depends on cpr_pkg for the job type.
`timescale 1ns / 1ps
`default_nettype none
module cpr_fifo import cpr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire cpr_job_t wjob,
  input  wire logic     pop,
  output cpr_job_t      rjob,
  output cpr_qstat_t    stat
);
  cpr_job_t   mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign rjob       = mem_r[rp_r];
  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wjob;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

/* sv/cpr_back.sv */
// Point generator: for each queued job, divides out each point angle, turns
// it into a point with a CORDIC rotation and drives the output register.
// Depends on cpr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cpr_back import cpr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [30:0] radius,
  input  wire cpr_job_t    q_job,
  input  wire cpr_qstat_t  q_stat,
  output logic             q_pop,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,
  output logic             out_tlast
);
  localparam logic [2:0] B_IDLE = 3'd0, B_MUL = 3'd1, B_DIV = 3'd2,
                         B_SET = 3'd3, B_ROT = 3'd4, B_OUT = 3'd5;

  logic [2:0]         state_r;
  cpr_job_t           job_r;
  logic [PW-1:0]      i_r;
  logic [38:0]        x0_r;
  logic [NW-1:0]      num_r;
  logic [7:0]         den_r;
  logic [8:0]         rem_r;
  logic [4:0]         dc_r;
  logic signed [41:0] x_r, y_r;
  logic signed [33:0] z_r;
  logic [ITW-1:0]     it_r;
  logic               ov_r, last_r;
  logic [31:0]        ox_r, oy_r;

  logic [60:0]        gprod;
  logic [8:0]         remw;
  logic               qbit;
  logic [15:0]        ang, ang_q;
  logic [31:0]        a32;
  logic signed [41:0] xs, ys;
  logic signed [33:0] xr, yr, sx, sy;
  logic [31:0]        satx, saty;
  logic               load;

  always_comb begin
    gprod = 61'(radius) * 61'(GAIN_Q30) + 61'(1 << 21);
    remw  = {rem_r[7:0], num_r[NW-1]};
    qbit  = (remw >= 9'(den_r));
    ang   = job_r.start + num_r[15:0];
    ang_q = ang + QUARTER_TURN;
    a32   = {ang, 16'd0};
    if (ang_q[15]) a32 = a32 - 32'h8000_0000;
    xs    = x_r >>> it_r;
    ys    = y_r >>> it_r;
    xr    = 34'((x_r + 42'sd128) >>> 8);
    yr    = 34'((y_r + 42'sd128) >>> 8);
    sx    = 34'(job_r.cx) + xr;
    sy    = 34'(job_r.cy) + yr;
    if (sx[33:31] == 3'b000 || sx[33:31] == 3'b111) satx = sx[31:0];
    else satx = sx[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    if (sy[33:31] == 3'b000 || sy[33:31] == 3'b111) saty = sy[31:0];
    else saty = sy[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    load  = (state_r == B_OUT) && (!ov_r || out_tready);
  end

  assign q_pop      = (state_r == B_IDLE) && !q_stat.empty;
  assign out_tvalid = ov_r;
  assign out_tdata  = {oy_r, ox_r};
  assign out_tlast  = last_r;

  always_ff @(posedge clk) begin
    if (load) begin
      ox_r   <= satx;
      oy_r   <= saty;
      last_r <= (i_r == job_r.p - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      ov_r    <= 1'b0;
    end else begin
      if (load) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (!q_stat.empty) begin
            job_r   <= q_job;
            i_r     <= '0;
            x0_r    <= gprod[60:22];
            state_r <= B_MUL;
          end
        end
        B_MUL: begin
          num_r   <= NW'(i_r) * NW'(job_r.s2) + NW'(job_r.d);
          den_r   <= {1'(0), job_r.d} << 1;
          rem_r   <= '0;
          dc_r    <= '0;
          state_r <= B_DIV;
        end
        B_DIV: begin
          // Restoring division; the numerator register fills with the quotient.
          rem_r <= qbit ? (remw - 9'(den_r)) : remw;
          num_r <= {num_r[NW-2:0], qbit};
          if (dc_r == 5'(NW - 1)) state_r <= B_SET;
          else dc_r <= dc_r + 1'b1;
        end
        B_SET: begin
          // Angles in the left half plane start from the negated x axis.
          x_r     <= ang_q[15] ? -42'(x0_r) : 42'(x0_r);
          y_r     <= '0;
          z_r     <= 34'($signed(a32));
          it_r    <= '0;
          state_r <= B_ROT;
        end
        B_ROT: begin
          if (z_r >= 0) begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - 34'(atab(5'(it_r)));
          end else begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + 34'(atab(5'(it_r)));
          end
          if (it_r == ITW'(CORDIC_STEPS - 1)) state_r <= B_OUT;
          else it_r <= it_r + 1'b1;
        end
        B_OUT: begin
          if (load) begin
            if (i_r == job_r.p - 1'b1) begin
              state_r <= B_IDLE;
            end else begin
              i_r     <= i_r + 1'b1;
              state_r <= B_MUL;
            end
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* sv/convex_polygon_round_buffer_core.sv */
// Convex polygon round buffer top level: configuration registers, front end,
// job queue and point generator. Depends on cpr_pkg and all cpr_ modules.
//
// Usage: each input word is one vertex of a counter-clockwise convex polygon
// with its two neighbors (in_tuser set: the vertex alone, full circle). The
// block returns the rounded-offset arc around the vertex as a run of point
// words on the out_ channel, the final one marked by out_tlast.
// Configuration: cfg_we writes radius (index 0) or points per circle (index 1);
// write only while the block is idle (not enforced by the block); no read-back.
// Per vertex, the front end runs two CORDIC vectoring passes of 16 iterations,
// each after an operand normalization, plus setup states; an in_tuser vertex
// skips the passes. For each arc point the back end runs a restoring division
// for the point angle, a 16-iteration CORDIC rotation and setup and output
// states, and starts no new point until the last one is in the output register.
// The two-entry job queue lets the front end work ahead.
// Reset clears all control state and loads radius 1.0 and 16 points per circle.
// When the receiver stalls, the output word holds and the back end waits;
// the front end keeps accepting vertices until the queue fills.
`timescale 1ns / 1ps
`default_nettype none
module convex_polygon_round_buffer_core import cpr_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [191:0] in_tdata,   // prev_x, prev_y, curr_x, curr_y, next_x, next_y
  input  wire logic         in_tuser,   // single_point
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [63:0]       out_tdata,  // point_x, point_y
  output logic              out_tlast,
  input  wire logic         cfg_we,
  input  wire logic         cfg_addr,
  input  wire logic [30:0]  cfg_wdata
);
  logic [30:0] radius_r;
  logic [6:0]  cv_r;
  logic        q_push, q_pop;
  cpr_job_t    wjob, rjob;
  cpr_qstat_t  q_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 31'd65536;
      cv_r     <= 7'd16;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_RADIUS: radius_r <= cfg_wdata;
        REG_CV:     cv_r     <= cfg_wdata[6:0];
        default:    cv_r     <= cv_r;
      endcase
    end
  end

  cpr_front u_front (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .cv(cv_r),
    .q_push(q_push), .q_job(wjob), .q_stat(q_stat)
  );

  cpr_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(q_push), .wjob(wjob),
    .pop(q_pop), .rjob(rjob), .stat(q_stat)
  );

  cpr_back u_back (
    .clk(clk), .rst_n(rst_n), .radius(radius_r), .q_job(rjob), .q_stat(q_stat),
    .q_pop(q_pop), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  a_no_out_after_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_tvalid) else $error("output word right after reset");

  a_queue_stat: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty)) else $error("queue full and empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full) else $error("job pushed into full queue");
endmodule
`default_nettype wire
